>>> rtl/newton_square_root_defines.svh
// Assertion macros for the Newton square root block.
// Needs nothing; included by files that check their own logic.
`ifndef NEWTON_SQUARE_ROOT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define NSR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nsr assertion failed");

// Check a property on every clock edge, reset included.
`define NSR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nsr assertion failed");

`endif

>>> rtl/nsr_pkg.sv
// Shared widths, defaults and register indexes for the Newton square root.
// No dependencies.
package nsr_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int TOL_W         = 17;
  localparam int STEP_W        = 6;
  localparam int SQ_W          = 64;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 17'd1;
  localparam logic [STEP_W-1:0] STEPS_RESET = 6'd32;
endpackage

>>> rtl/nsr_mul.sv
// Bit-serial squarer: one multiplier bit per cycle, product kept to SQ_W bits.
// Depends on nsr_pkg.
module nsr_mul #(
  parameter int W = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [W-1:0]            a,
  output logic                    done,
  output logic [nsr_pkg::SQ_W-1:0] prod
);
  import nsr_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [SQ_W-1:0] mcand;
  logic [W-1:0]    mplier;
  logic [CW-1:0]   cnt;

  // Shift and add one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod   <= '0;
        mcand  <= SQ_W'(a);
        mplier <= a;
        cnt    <= CW'(W);
      end else if (cnt != '0) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CW'(1);
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end
endmodule

>>> rtl/nsr_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on nsr_pkg for the house import only.
module nsr_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot
);
  import nsr_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;

  assign trial = {rem, quot[W-1]};

  // Shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quot <= dividend;
        dsr  <= divisor;
        cnt  <= CW'(W);
      end else if (cnt != '0) begin
        if (trial >= {1'b0, dsr}) begin
          rem  <= W'(trial - {1'b0, dsr});
          quot <= {quot[W-2:0], 1'b1};
        end else begin
          rem  <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) done <= 1'b1;
      end
    end
  end
endmodule

>>> rtl/newton_square_root.sv
// Channel   | valid     | stall      | payload
// input     | in_valid  | in_stall   | operand
// output    | out_valid | out_stall  | root, negative_input, step_cap_hit
//
// One word at a time. A negative or zero operand goes from S_IDLE to S_DONE and on to
// the output register. Otherwise each Newton step is a serial square of the guess, a
// check, and a serial divide, up to max_steps steps plus a final square. in_stall is
// high while a word is in work.
// Reset clears control and loads the register defaults; a full output register
// holds the finished word until out_stall drops.
// Depends on nsr_pkg, nsr_mul, nsr_div and newton_square_root_defines.svh.
`include "newton_square_root_defines.svh"
module newton_square_root #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [nsr_pkg::DATA_W-1:0] operand,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [nsr_pkg::DATA_W-1:0] root,
  output logic                           negative_input,
  output logic                           step_cap_hit,
  input  logic                           cfg_we,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsr_pkg::TOL_W-1:0]      cfg_data
);
  import nsr_pkg::*;

  localparam int GW  = DATA_W + FRAC_BITS;
  localparam int SQW = SQ_W - FRAC_BITS;
  localparam logic [GW-1:0]     ONE     = GW'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] NEG_ONE = ~(DATA_W'(1) << FRAC_BITS) + DATA_W'(1);
  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t              state;
  logic [TOL_W-1:0]    tolerance;
  logic [STEP_W-1:0]   max_steps;
  logic [STEP_W-1:0]   steps;
  logic [DATA_W-2:0]   raw;
  logic [GW-1:0]       guess;
  logic [GW-1:0]       guess_next;
  logic [DATA_W-1:0]   res_root;
  logic                res_neg;
  logic                res_cap;

  logic                in_take;
  logic                mul_start, mul_done, div_start, div_done;
  logic [GW-1:0]       mul_a;
  logic [SQ_W-1:0]     prod;
  logic [GW-1:0]       quot;
  logic [GW:0]         sum;
  logic [SQW-1:0]      sq, raw_ext, diff;
  logic                tol_met;
  logic [DATA_W-1:0]   guess_sat;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Next guess from the quotient, never zero
  assign sum        = {1'b0, quot} + {1'b0, guess};
  assign guess_next = (sum[GW:1] == '0) ? GW'(1) : sum[GW:1];

  // Convergence test on the truncated square
  assign sq      = prod[SQ_W-1:FRAC_BITS];
  assign raw_ext = SQW'(raw);
  assign diff    = (sq >= raw_ext) ? (sq - raw_ext) : (raw_ext - sq);
  assign tol_met = diff < SQW'(tolerance);
  assign guess_sat = (guess > GW'(MAX_POS)) ? MAX_POS : guess[DATA_W-1:0];

  // Launch the serial units
  assign mul_start = (in_take && !operand[DATA_W-1] && operand != '0) ||
                     (state == S_DIVIDE && div_done);
  assign mul_a     = (state == S_IDLE) ? ONE : guess_next;
  assign div_start = (state == S_CHECK) && !tol_met && (steps < max_steps);

  nsr_mul #(.W(GW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .done(mul_done), .prod(prod)
  );

  nsr_div #(.W(GW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(GW'(raw) << FRAC_BITS),
    .divisor(guess), .done(div_done), .quot(quot)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      max_steps <= STEPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tolerance <= cfg_data;
        CFG_MAX_STEPS: max_steps <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      steps     <= '0;
    end else begin
      // Drop a delivered word unless a new one replaces it this cycle
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            raw   <= operand[DATA_W-2:0];
            guess <= ONE;
            steps <= '0;
            if (operand[DATA_W-1]) begin
              res_root <= NEG_ONE;
              res_neg  <= 1'b1;
              res_cap  <= 1'b0;
              state    <= S_DONE;
            end else if (operand == '0) begin
              res_root <= '0;
              res_neg  <= 1'b0;
              res_cap  <= 1'b0;
              state    <= S_DONE;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          if (mul_done) state <= S_CHECK;
        end
        S_CHECK: begin
          res_root <= guess_sat;
          res_neg  <= 1'b0;
          if (tol_met) begin
            res_cap <= 1'b0;
            state   <= S_DONE;
          end else if (steps >= max_steps) begin
            res_cap <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            guess <= guess_next;
            steps <= steps + STEP_W'(1);
            state <= S_SQUARE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            root           <= res_root;
            negative_input <= res_neg;
            step_cap_hit   <= res_cap;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NSR_ASSERT(a_take_busy, clk, rst, in_take |=> in_stall)
  `NSR_ASSERT(a_neg_word, clk, rst,
    (out_valid && negative_input) |-> (root == NEG_ONE && !step_cap_hit))
  `NSR_ASSERT(a_step_bound, clk, rst, (state == S_DIVIDE) |-> (steps < max_steps))
  `NSR_ASSERT(a_units_apart, clk, rst, !(mul_start && div_start))
  `NSR_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!out_valid && !in_stall))
endmodule

>>> dv/nsr_checker.sv
// Checker for the Newton square root block: watches both channels, predicts
// each root from the operand and the live register values, and counts mismatches.
// Depends on nsr_pkg.
`timescale 1ns / 1ps
module nsr_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [nsr_pkg::DATA_W-1:0] operand,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [nsr_pkg::DATA_W-1:0] root,
  input  logic                              negative_input,
  input  logic                              step_cap_hit,
  input  logic                              cfg_we,
  input  logic [nsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsr_pkg::TOL_W-1:0]         cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import nsr_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] root;
    logic              neg;
    logic              cap;
  } root_word_t;

  logic [TOL_W-1:0]  tol;
  logic [STEP_W-1:0] steps_max;
  root_word_t        roots_due[$];

  assign pending = roots_due.size();

  // Newton iteration in 64-bit integer fixed point.
  function automatic root_word_t newton_root(logic [DATA_W-1:0] x,
                                             logic [TOL_W-1:0] t, logic [STEP_W-1:0] n);
    root_word_t r;
    logic [63:0] g, sq, d, q;
    int k;
    r = '0;
    g = 64'd1 << FRAC_BITS_DEF;
    k = 0;
    if (x[DATA_W-1]) begin
      r.root = -(32'd1 << FRAC_BITS_DEF);
      r.neg = 1'b1;
      return r;
    end
    if (x == 0) return r;
    forever begin
      sq = (g * g) >> FRAC_BITS_DEF;
      d = (sq >= {32'd0, x}) ? sq - x : x - sq;
      if (d < t) break;
      if (k >= n) begin
        r.cap = 1'b1;
        break;
      end
      q = ({32'd0, x} << FRAC_BITS_DEF) / g;
      g = (q + g) >> 1;
      if (g == 0) g = 1;
      k++;
    end
    r.root = (g > 64'h7FFFFFFF) ? 32'h7FFFFFFF : g[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    root_word_t want;
    if (rst) begin
      tol <= TOL_RESET;
      steps_max <= STEPS_RESET;
      fail_count <= 0;
      roots_due.delete();
    end else begin
      // Track register writes.
      if (cfg_we) begin
        if (cfg_index == CFG_TOLERANCE) tol <= cfg_data;
        else steps_max <= cfg_data[STEP_W-1:0];
      end
      // Predict each accepted word.
      if (in_valid && !in_stall) roots_due.push_back(newton_root(operand, tol, steps_max));
      // Compare each delivered word.
      if (out_valid && !out_stall) begin
        if (roots_due.size() == 0) begin
          $error("unexpected result word root=%0d", root);
          fail_count <= fail_count + 1;
        end else begin
          want = roots_due.pop_front();
          if (root !== want.root || negative_input !== want.neg ||
              step_cap_hit !== want.cap) begin
            if (root !== want.root)
              $error("root: expected %0d actual %0d", $signed(want.root), root);
            if (negative_input !== want.neg)
              $error("negative_input: expected %0b actual %0b", want.neg, negative_input);
            if (step_cap_hit !== want.cap)
              $error("step_cap_hit: expected %0b actual %0b", want.cap, step_cap_hit);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> dv/tb.sv
// Testbench top for the Newton square root: clock, reset, stimulus, verdict.
// Depends on nsr_pkg, newton_square_root and nsr_checker.
`timescale 1ns / 1ps
module tb;
  import nsr_pkg::*;

  localparam int LIMIT = 40000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DATA_W-1:0] operand = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] root;
  logic negative_input, step_cap_hit;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TOLERANCE;
  logic [TOL_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int cycle = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  newton_square_root uut (.*);
  nsr_checker chk (.*);

  always #2 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the output at random, with one long hold-off.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= !quiet && ($urandom_range(99) < 20);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain every result, then let any tail of work settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Offer one word, with a random gap before it unless quiet is set.
  task automatic send_word(logic [DATA_W-1:0] v);
    if (!quiet) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    operand <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(65535);
      2: return $urandom_range(32'h7FFF_FFFF, 32'h7FF0_0000);
      3: return 32'h8000_0000 | $urandom;
      default: return {1'b0, 31'($urandom)};
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] edge_vals[13];
    edge_vals = '{32'h0, 32'h1, 32'h2, 32'hFFFF, 32'h10000, 32'h40000, 32'h7FFFFFFF,
                  32'h80000000, 32'hFFFFFFFF, 32'hFFFF0000, 32'h00FF_FF00,
                  32'h5555_5555, 32'h2AAA_AAAA};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: defaults, then a large tolerance with one step, then both registers at zero.
    foreach (edge_vals[i]) send_word(edge_vals[i]);
    drain();
    write_reg(CFG_TOLERANCE, 17'd65536);
    write_reg(CFG_MAX_STEPS, 17'd1);
    for (int i = 0; i < 5; i++) send_word(edge_vals[i + 2]);
    drain();
    write_reg(CFG_TOLERANCE, 17'd0);
    write_reg(CFG_MAX_STEPS, 17'd0);
    for (int i = 0; i < 5; i++) send_word(edge_vals[i + 1]);
    drain();

    // Random phases over several settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_TOLERANCE, ph == 0 ? 17'd1 : 17'($urandom_range(65536)));
      write_reg(CFG_MAX_STEPS, ph == 1 ? 17'd63 : 17'($urandom_range(63)));
      quiet = (ph == 2);
      if (ph == 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 120; i++) send_word(rand_operand());
      drain();
    end
    quiet = 1'b0;

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/nsr_pkg.sv
rtl/nsr_mul.sv
rtl/nsr_div.sv
rtl/newton_square_root.sv
dv/nsr_checker.sv
dv/tb.sv
